### src/lkt_pkg.sv
`default_nettype none

package lkt_pkg;

  localparam int ENTRIES  = 8;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = 3;
  localparam int RANK_W   = 3;
  localparam int OCC_W    = 4;
  localparam int CAP_W    = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

  typedef struct packed {
    logic load;
    logic decide;
    logic commit;
  } lkt_cmd_t;

endpackage

`default_nettype wire

### src/lru_key_tracker_core.sv
// Fully associative LRU key tracker with eight entries. An item is taken when start is high
// and busy is low; its result (hit, evicted, evicted_key) is loaded into the result registers
// and done is high for exactly one cycle, and the receiver cannot hold it off. The key is
// latched in the idle state as the item is accepted, the lookup state registers the parallel
// tag compare and victim / free-slot selection, and the commit state updates ranks and keys
// and loads the result registers; done is registered from the commit state. busy is high in
// the lookup and commit states, so a new item cannot be taken before the last is through, but
// one can be started in the cycle that done is high. cfg_we writes the capacity register
// (values above eight act as eight, zero acts as one) and is meant for use while busy is low.
`default_nettype none

module lru_key_tracker_core
  import lkt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KEY_BITS-1:0] key,
  input  wire logic                cfg_we,
  input  wire logic [CAP_W-1:0]    cfg_data,
  output logic                     done,
  output logic                     hit,
  output logic                     evicted,
  output logic [KEY_BITS-1:0]      evicted_key
);

  lkt_cmd_t cmd;
  logic     start_ok;

  assign start_ok = start && !busy;

  lkt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start_ok),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  lkt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .key         (key),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .hit         (hit),
    .evicted     (evicted),
    .evicted_key (evicted_key)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy ##1 busy ##1 done)
    else $error("item did not run through lookup and commit");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> !evicted)
    else $error("eviction reported on a hit");

  a_key_zero: assert property (@(posedge clk) disable iff (rst)
    done && !evicted |-> evicted_key == '0)
    else $error("evicted key not zero without eviction");

endmodule

`default_nettype wire

### src/lkt_ctrl.sv
`default_nettype none

module lkt_ctrl
  import lkt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  output logic      done,
  output lkt_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOK   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.decide = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.commit;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

### src/lkt_datapath.sv
`default_nettype none

module lkt_datapath
  import lkt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lkt_cmd_t            cmd,
  input  wire logic [KEY_BITS-1:0] key,
  input  wire logic                cfg_we,
  input  wire logic [CAP_W-1:0]    cfg_data,
  output logic                     hit,
  output logic                     evicted,
  output logic [KEY_BITS-1:0]      evicted_key
);

  logic [KEY_BITS-1:0] key_store [ENTRIES];
  logic [ENTRIES-1:0]  entry_valid;
  logic [RANK_W-1:0]   recency_rank [ENTRIES];
  logic [OCC_W-1:0]    occupancy;
  logic [CAP_W-1:0]    capacity;

  logic [KEY_BITS-1:0] key_q;

  // decision registers
  logic                d_hit;
  logic                d_evict;
  logic                d_insert;
  logic                d_age_all;
  logic [IDX_W-1:0]    d_slot;
  logic [RANK_W-1:0]   d_limit;
  logic [KEY_BITS-1:0] d_ev_key;

  logic                match_found;
  logic [IDX_W-1:0]    match_idx;
  logic                victim_found;
  logic [IDX_W-1:0]    victim_idx;
  logic [RANK_W-1:0]   victim_rank;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic [CAP_W-1:0]    eff_cap;
  logic                full;

  always_comb begin
    match_found  = 1'b0;
    match_idx    = '0;
    victim_found = 1'b0;
    victim_idx   = '0;
    victim_rank  = '0;
    free_found   = 1'b0;
    free_idx     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!match_found && entry_valid[i] && key_store[i] == key_q) begin
        match_found = 1'b1;
        match_idx   = IDX_W'(i);
      end
      if (entry_valid[i] && (!victim_found || recency_rank[i] > victim_rank)) begin
        victim_found = 1'b1;
        victim_idx   = IDX_W'(i);
        victim_rank  = recency_rank[i];
      end
      if (!free_found && !entry_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CAP_W'(1);
    end else if (capacity > CAP_W'(ENTRIES)) begin
      eff_cap = CAP_W'(ENTRIES);
    end else begin
      eff_cap = capacity;
    end
  end

  assign full = (CAP_W'(occupancy) >= eff_cap);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
      capacity    <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (cmd.commit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) != d_slot && entry_valid[i] &&
              (d_age_all || recency_rank[i] < d_limit)) begin
            recency_rank[i] <= recency_rank[i] + RANK_W'(1);
          end
        end
        recency_rank[d_slot] <= '0;
        if (d_insert) begin
          entry_valid[d_slot] <= 1'b1;
          occupancy           <= occupancy + OCC_W'(1);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q <= key;
    end
    if (cmd.decide) begin
      d_hit   <= match_found;
      d_limit <= recency_rank[match_idx];
      if (match_found) begin
        d_slot    <= match_idx;
        d_age_all <= 1'b0;
        d_evict   <= 1'b0;
        d_insert  <= 1'b0;
        d_ev_key  <= '0;
      end else if (full) begin
        d_slot    <= victim_idx;
        d_age_all <= 1'b1;
        d_evict   <= 1'b1;
        d_insert  <= 1'b0;
        d_ev_key  <= key_store[victim_idx];
      end else begin
        d_slot    <= free_idx;
        d_age_all <= 1'b1;
        d_evict   <= 1'b0;
        d_insert  <= 1'b1;
        d_ev_key  <= '0;
      end
    end
    if (cmd.commit) begin
      if (!d_hit) begin
        key_store[d_slot] <= key_q;
      end
      hit         <= d_hit;
      evicted     <= d_evict;
      evicted_key <= d_ev_key;
    end
  end

endmodule

`default_nettype wire
